### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### design/lcag_pkg.sv
package lcag_pkg;

  // default largest grid side
  localparam int MAX_SIDE_DEF = 64;

  // field widths
  localparam int CFG_W = 7;
  localparam int COORD_W = 6;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST = 7'd50;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd50;

  // opcodes
  localparam logic [1:0] OP_TOGGLE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_ADVANCE = 2'd3;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // row write source
  localparam logic [1:0] WR_TOGGLE = 2'd0;
  localparam logic [1:0] WR_CLEAR = 2'd1;
  localparam logic [1:0] WR_LIFE = 2'd2;

  typedef struct packed {
    logic       latch;    // capture item, zero sweep state
    logic       rd_en;    // read a row this cycle
    logic       rd_item;  // read address from item row, else step counter
    logic       wr_en;    // write a row this cycle
    logic [1:0] wr_sel;   // write source
    logic       shift;    // shift row window down one row
    logic       step;     // advance step counter
    logic       strobe;   // capture result
  } lcag_cmd_t;

  typedef struct packed {
    logic rd_ok;     // step below rows in use
    logic clr_wr;    // clear sweep has a row to write back
    logic adv_wr;    // advance sweep has a row to write back
    logic clr_last;  // last cycle of clear sweep
    logic adv_last;  // last cycle of advance sweep
  } lcag_stat_t;

endpackage

### design/life_cellular_automaton_grid.sv
// game of life grid (birth on 3, survival on 2 or 3, dead border, no wrap).
// one command per start beat; busy is high while a command runs and start is
// ignored then. every command gives one result beat: done is high for a
// single cycle with cell_alive and addr_valid, and the receiver cannot stall,
// so the result must be taken in that cycle. done comes up while busy is
// already low, so a new start may sit in the same cycle as done.
// toggle and read pass through the final read and result states only;
// clear and advance first sweep the rows in use (grid_height capped at
// MAX_SIDE), reading and writing one stored row per cycle through the
// row memory. after reset all cells are dead at once: each row has a
// valid bit, so there is no clearing pass. grid_width and grid_height
// are written on the cfg channel, which is always ready; write them only
// while busy is low.
module life_cellular_automaton_grid #(
  parameter int MAX_SIDE = lcag_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [lcag_pkg::COORD_W-1:0]  col,
  input  logic [lcag_pkg::COORD_W-1:0]  row,
  // result channel
  output logic                          done,
  output logic                          cell_alive,
  output logic                          addr_valid,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [lcag_pkg::CFG_W-1:0]    cfg_data
);

  lcag_pkg::lcag_cmd_t  cmd;
  lcag_pkg::lcag_stat_t stat;

  // registers always take a write beat
  assign cfg_ready = 1'b1;

  // sequencer: idle, clear sweep, advance sweep, final read, result
  lcag_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  // row memory, row window, neighbour count and result registers
  lcag_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .col        (col),
    .row        (row),
    .cmd        (cmd),
    .stat       (stat),
    .cell_alive (cell_alive),
    .addr_valid (addr_valid)
  );

endmodule

### design/lcag_ctrl.sv
module lcag_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            opcode,
  input  lcag_pkg::lcag_stat_t  stat,
  output logic                  busy,
  output logic                  done,
  output lcag_pkg::lcag_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_ADV  = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FOUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FOUT);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= opcode;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          case (opcode)
            lcag_pkg::OP_CLEAR:   state_next = S_CLR;
            lcag_pkg::OP_ADVANCE: state_next = S_ADV;
            default:              state_next = S_FRD;
          endcase
        end
      end
      S_CLR: begin
        cmd.rd_en  = stat.rd_ok;
        cmd.wr_en  = stat.clr_wr;
        cmd.wr_sel = lcag_pkg::WR_CLEAR;
        cmd.step   = 1'b1;
        if (stat.clr_last) begin
          state_next = S_FRD;
        end
      end
      S_ADV: begin
        cmd.rd_en  = stat.rd_ok;
        cmd.wr_en  = stat.adv_wr;
        cmd.wr_sel = lcag_pkg::WR_LIFE;
        cmd.shift  = 1'b1;
        cmd.step   = 1'b1;
        if (stat.adv_last) begin
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
        state_next  = S_FOUT;
      end
      S_FOUT: begin
        cmd.wr_en  = (op == lcag_pkg::OP_TOGGLE);
        cmd.wr_sel = lcag_pkg::WR_TOGGLE;
        cmd.strobe = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/lcag_datapath.sv
module lcag_datapath #(
  parameter int MAX_SIDE = lcag_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lcag_pkg::CFG_W-1:0]    cfg_data,
  input  logic [lcag_pkg::COORD_W-1:0]  col,
  input  logic [lcag_pkg::COORD_W-1:0]  row,
  input  lcag_pkg::lcag_cmd_t           cmd,
  output lcag_pkg::lcag_stat_t          stat,
  output logic                          cell_alive,
  output logic                          addr_valid
);

  localparam int IDXW = $clog2(MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE + 2);
  localparam int SW = (CW > lcag_pkg::CFG_W) ? CW : lcag_pkg::CFG_W;
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);

  logic [lcag_pkg::CFG_W-1:0]   grid_width;
  logic [lcag_pkg::CFG_W-1:0]   grid_height;
  logic [SW-1:0]                w_use;
  logic [SW-1:0]                h_use;
  logic [lcag_pkg::COORD_W-1:0] col_q;
  logic [lcag_pkg::COORD_W-1:0] row_q;
  logic [SW-1:0]                step;
  logic [SW-1:0]                step_m1;
  logic [SW-1:0]                step_m2;
  logic [IDXW-1:0]              col_idx;
  logic [IDXW-1:0]              row_idx;
  logic [IDXW-1:0]              rd_addr;
  logic [IDXW-1:0]              wr_addr;
  logic [MAX_SIDE-1:0]          wr_data;
  logic                         wr_fire;
  logic                         flip;
  logic                         item_valid;

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld;
  logic [MAX_SIDE-1:0] rd_q;
  logic                rd_ok_q;
  logic [MAX_SIDE-1:0] rdata;

  logic [MAX_SIDE-1:0] above;
  logic [MAX_SIDE-1:0] cur;
  logic [MAX_SIDE-1:0] wmask;
  logic [MAX_SIDE-1:0] ma;
  logic [MAX_SIDE-1:0] mc;
  logic [MAX_SIDE-1:0] mb;
  logic [MAX_SIDE-1:0] life_row;
  logic [3:0]          nbr [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lcag_pkg::GRID_WIDTH_RST;
      grid_height <= lcag_pkg::GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcag_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        lcag_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_use = (SW'(grid_width) > SIDE_MAX) ? SIDE_MAX : SW'(grid_width);
  assign h_use = (SW'(grid_height) > SIDE_MAX) ? SIDE_MAX : SW'(grid_height);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      col_q <= col;
      row_q <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.latch) begin
      step <= '0;
    end else if (cmd.step) begin
      step <= step + SW'(1);
    end
  end

  assign step_m1 = step - SW'(1);
  assign step_m2 = step - SW'(2);

  assign stat.rd_ok    = (step < h_use);
  assign stat.clr_wr   = (step != '0);
  assign stat.adv_wr   = (step >= SW'(2));
  assign stat.clr_last = (step == h_use);
  assign stat.adv_last = (step == h_use + SW'(1));

  assign col_idx = IDXW'(col_q);
  assign row_idx = IDXW'(row_q);
  assign item_valid = (SW'(col_q) < w_use) && (SW'(row_q) < h_use);

  assign rd_addr = cmd.rd_item ? row_idx : step[IDXW-1:0];

  // columns in use
  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      wmask[c] = (SW'(c) < w_use);
    end
  end

  // row store, rows never written read as dead
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_fire) begin
        row_vld[wr_addr] <= 1'b1;
      end
      rd_ok_q <= cmd.rd_en && row_vld[rd_addr];
    end
  end

  assign rdata = rd_ok_q ? rd_q : '0;

  // three row window, old generation
  always_ff @(posedge clk) begin
    if (rst) begin
      above <= '0;
      cur   <= '0;
    end else if (cmd.latch) begin
      above <= '0;
      cur   <= '0;
    end else if (cmd.shift) begin
      above <= cur;
      cur   <= rdata;
    end
  end

  assign ma = above & wmask;
  assign mc = cur & wmask;
  assign mb = rdata & wmask;

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      nbr[c] = 4'(ma[c]) + 4'(mb[c]);
      if (c > 0) begin
        nbr[c] = nbr[c] + 4'(ma[c-1]) + 4'(mc[c-1]) + 4'(mb[c-1]);
      end
      if (c < MAX_SIDE - 1) begin
        nbr[c] = nbr[c] + 4'(ma[c+1]) + 4'(mc[c+1]) + 4'(mb[c+1]);
      end
      if (wmask[c]) begin
        life_row[c] = (nbr[c] == 4'd3) || ((nbr[c] == 4'd2) && cur[c]);
      end else begin
        life_row[c] = cur[c];
      end
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      lcag_pkg::WR_CLEAR: begin
        wr_addr = step_m1[IDXW-1:0];
        wr_data = rdata & ~wmask;
      end
      lcag_pkg::WR_LIFE: begin
        wr_addr = step_m2[IDXW-1:0];
        wr_data = life_row;
      end
      default: begin
        wr_addr = row_idx;
        wr_data = rdata ^ (MAX_SIDE'(1) << col_idx);
      end
    endcase
  end

  assign flip = cmd.wr_en && (cmd.wr_sel == lcag_pkg::WR_TOGGLE);
  assign wr_fire = cmd.wr_en && ((cmd.wr_sel != lcag_pkg::WR_TOGGLE) || item_valid);

  always_ff @(posedge clk) begin
    if (cmd.strobe) begin
      addr_valid <= item_valid;
      cell_alive <= item_valid && (rdata[col_idx] ^ flip);
    end
  end

endmodule

### design/lcag_checker.sv
`include "assert_macros.svh"

module lcag_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    opcode,
  input logic                          done,
  input logic                          cell_alive,
  input logic                          addr_valid
);

  logic cmd_accept;
  logic read_accept;

  assign cmd_accept  = start && !busy;
  assign read_accept = cmd_accept && (opcode == lcag_pkg::OP_READ);

  `ASSERT_PROP(a_busy_after_start, clk, rst, cmd_accept |=> busy, "accepted command not busy")
  `ASSERT_NEVER(a_done_while_busy, clk, rst, done && busy, "result while busy")
  `ASSERT_PROP(a_done_single, clk, rst, done |=> !done, "result beat longer than one cycle")
  `ASSERT_NEVER(a_dead_outside, clk, rst, done && !addr_valid && cell_alive, "live cell off grid")
  `ASSERT_PROP(a_read_latency, clk, rst, read_accept |-> ##3 done, "read result late")

endmodule

bind life_cellular_automaton_grid lcag_checker u_lcag_checker (.*);

### test/tb_life_cellular_automaton_grid.sv
`timescale 1ns / 100ps

module tb_life_cellular_automaton_grid;

  // largest grid side the block is built with
  localparam int SIDE = lcag_pkg::MAX_SIDE_DEF;
  // cycles with no beat on any channel before the run is declared hung;
  // an advance on a full grid sweeps every row, sender gaps are short
  localparam int STALL_LIMIT = 4000;
  // settle time at the end, well above the slowest command
  localparam int TAIL_CYCLES = 2 * SIDE + 16;

  // one expected or observed result beat
  typedef struct packed {
    logic alive;
    logic valid;
  } cell_result_t;

  // directed rows are either commands or register writes
  typedef enum logic {
    ROW_CMD,
    ROW_REG
  } row_kind_t;

  // how a directed command is checked
  typedef enum logic {
    CHK_PRED,   // against the predictor
    CHK_TYPED   // against the value typed in the row
  } row_check_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] op;
    logic [5:0] c;
    logic [5:0] r;
    row_check_t chk;
    logic       alive;
    logic       valid;
    logic       reg_sel;
    logic [6:0] reg_value;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 29;

  // directed part, starting from the reset grid of 50 x 50
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty grid after reset, in and out of range
    '{ROW_CMD, lcag_pkg::OP_READ,    6'd0,  6'd0,  CHK_TYPED, 1'b0, 1'b1, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_READ,    6'd63, 6'd63, CHK_TYPED, 1'b0, 1'b0, 1'b0, 7'd0},
    // last cell in use, then first column past the edge
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd49, 6'd49, CHK_TYPED, 1'b1, 1'b1, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd50, 6'd0,  CHK_TYPED, 1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_READ,    6'd49, 6'd49, CHK_TYPED, 1'b1, 1'b1, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd49, 6'd49, CHK_TYPED, 1'b0, 1'b1, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd0,  6'd0,  CHK_TYPED, 1'b1, 1'b1, 1'b0, 7'd0},
    // clear addressed outside the grid still clears
    '{ROW_CMD, lcag_pkg::OP_CLEAR,   6'd63, 6'd0,  CHK_TYPED, 1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_READ,    6'd0,  6'd0,  CHK_TYPED, 1'b0, 1'b1, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd0,  6'd0,  CHK_TYPED, 1'b0, 1'b1, 1'b0, 7'd0},
    // blinker in the middle, two generations
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd10, 6'd10, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd11, 6'd10, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd12, 6'd10, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd11, 6'd9,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd12, 6'd10, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    // birth in the top-left corner against the dead border
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd0,  6'd0,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd1,  6'd0,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd0,  6'd1,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd1,  6'd1,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    // same in the bottom-right corner, no wrap to the far side
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd48, 6'd49, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd49, 6'd48, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd49, 6'd49, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd48, 6'd48, CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    // zero width: nothing in use, every address invalid
    '{ROW_REG, lcag_pkg::OP_READ,    6'd0,  6'd0,  CHK_PRED,  1'b0, 1'b0,
      lcag_pkg::CFG_GRID_WIDTH, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_READ,    6'd0,  6'd0,  CHK_TYPED, 1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd1,  6'd1,  CHK_TYPED, 1'b0, 1'b0, 1'b0, 7'd0},
    // oversized width is capped, so column 63 is in use
    '{ROW_REG, lcag_pkg::OP_READ,    6'd0,  6'd0,  CHK_PRED,  1'b0, 1'b0,
      lcag_pkg::CFG_GRID_WIDTH, 7'd127},
    '{ROW_CMD, lcag_pkg::OP_TOGGLE,  6'd63, 6'd0,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0},
    '{ROW_CMD, lcag_pkg::OP_ADVANCE, 6'd1,  6'd1,  CHK_PRED,  1'b0, 1'b0, 1'b0, 7'd0}
  };

  // random phases: grid sizes, extremes among them, and sender idling
  localparam int PHASES = 12;
  localparam int CMDS_PER_PHASE = 40;
  localparam logic [6:0] PHASE_W [PHASES] = '{
    7'd8, 7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd13, 7'd64, 7'd1, 7'd50, 7'd16, 7'd100
  };
  localparam logic [6:0] PHASE_H [PHASES] = '{
    7'd8, 7'd1, 7'd64, 7'd9, 7'd3, 7'd127, 7'd6, 7'd1, 7'd64, 7'd50, 7'd16, 7'd20
  };
  localparam int IDLE_PCT [4] = '{0, 58, 15, 58};

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] opcode;
  logic [5:0] col;
  logic [5:0] row;
  logic       done;
  logic       cell_alive;
  logic       addr_valid;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  // predictor state: the cell array and the two size registers
  logic [SIDE-1:0] life_grid [SIDE];
  logic [6:0]      width_reg;
  logic [6:0]      height_reg;

  // results still owed by the block, oldest first
  cell_result_t    pending_results [$];
  int              error_count;
  int              stall_cycles;
  int              idle_pct;

  life_cellular_automaton_grid u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .col        (col),
    .row        (row),
    .done       (done),
    .cell_alive (cell_alive),
    .addr_valid (addr_valid),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // size register as the block uses it: anything above SIDE is SIDE
  function automatic int side_cap(input logic [6:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  // one generation over the rows and columns in use, from a snapshot of the
  // old generation; cells beyond the edge count dead and are left alone
  function automatic void next_generation(input int w, input int h);
    logic [SIDE-1:0] prev [SIDE];
    int n;
    prev = life_grid;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if ((dx != 0 || dy != 0) && y + dy >= 0 && y + dy < h &&
                x + dx >= 0 && x + dx < w)
              n += prev[y + dy][x + dx];
          end
        end
        life_grid[y][x] = (n == 3) || (n == 2 && prev[y][x]);
      end
    end
  endfunction

  // updates the grid for one command and returns the result it owes
  function automatic cell_result_t apply_command(input logic [1:0] op,
                                                 input logic [5:0] c,
                                                 input logic [5:0] r);
    int w;
    int h;
    logic in_grid;
    cell_result_t res;
    w = side_cap(width_reg);
    h = side_cap(height_reg);
    in_grid = (int'(c) < w) && (int'(r) < h);
    case (op)
      lcag_pkg::OP_TOGGLE: begin
        if (in_grid)
          life_grid[r][c] = ~life_grid[r][c];
      end
      lcag_pkg::OP_CLEAR: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            life_grid[y][x] = 1'b0;
      end
      lcag_pkg::OP_ADVANCE: begin
        next_generation(w, h);
      end
      default: begin
      end
    endcase
    res.alive = in_grid ? life_grid[r][c] : 1'b0;
    res.valid = in_grid;
    return res;
  endfunction

  // drives one command beat, idling first as the phase asks; start stays
  // high after the accepting edge until the next falling edge decides
  task automatic send_cmd(input logic [1:0] op, input logic [5:0] c,
                          input logic [5:0] r, input logic typed,
                          input cell_result_t typed_res);
    cell_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    col    <= c;
    row    <= r;
    do @(posedge clk); while (busy);
    // accepted at this edge: the predictor moves on in the same step
    res = apply_command(op, c, r);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // holds commands off until every owed result has come and the block is idle
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, only ever with the block idle
  task automatic write_reg(input logic sel, input logic [6:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (sel == lcag_pkg::CFG_GRID_WIDTH)
      width_reg = value;
    else
      height_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random commands on one grid size: mostly seeding and reading a small
  // window so that patterns live long enough to evolve, with advances
  // between them, rare clears and stray addresses anywhere in the field
  task automatic run_phase(input logic [6:0] wv, input logic [6:0] hv, input int n_cmds);
    int w;
    int h;
    int win_c;
    int win_r;
    int pick;
    logic [1:0] op;
    logic [5:0] c;
    logic [5:0] r;
    write_reg(lcag_pkg::CFG_GRID_WIDTH, wv);
    write_reg(lcag_pkg::CFG_GRID_HEIGHT, hv);
    w = side_cap(wv);
    h = side_cap(hv);
    win_c = (w > 8) ? $urandom_range(w - 8) : 0;
    win_r = (h > 8) ? $urandom_range(h - 8) : 0;
    for (int i = 0; i < n_cmds; i++) begin
      // now and then the sender waits for the block to run dry
      if ($urandom_range(99) < 5)
        drain_results();
      pick = $urandom_range(99);
      if (pick < 45)
        op = lcag_pkg::OP_TOGGLE;
      else if (pick < 72)
        op = lcag_pkg::OP_READ;
      else if (pick < 75)
        op = lcag_pkg::OP_CLEAR;
      else
        op = lcag_pkg::OP_ADVANCE;
      if ($urandom_range(99) < 80) begin
        c = 6'(win_c + $urandom_range(7));
        r = 6'(win_r + $urandom_range(7));
      end else begin
        c = 6'($urandom_range(63));
        r = 6'($urandom_range(63));
      end
      send_cmd(op, c, r, 1'b0, '0);
    end
  endtask

  // result side: every done beat is checked against the oldest expectation
  always @(posedge clk) begin
    cell_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: cell_alive %0b addr_valid %0b",
               cell_alive, addr_valid);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (cell_alive !== exp_res.alive) begin
          $error("cell_alive: expected %0b, actual %0b", exp_res.alive, cell_alive);
          error_count++;
        end
        if (addr_valid !== exp_res.valid) begin
          $error("addr_valid: expected %0b, actual %0b", exp_res.valid, addr_valid);
          error_count++;
        end
      end
    end
  end

  // any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // hang detection
  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("life_cellular_automaton_grid: mismatch");
    $finish;
  end

  initial begin
    cell_result_t typed_res;
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = lcag_pkg::OP_READ;
    col          = '0;
    row          = '0;
    cfg_valid    = 1'b0;
    cfg_index    = lcag_pkg::CFG_GRID_WIDTH;
    cfg_data     = '0;
    error_count  = 0;
    stall_cycles = 0;
    idle_pct     = 0;
    width_reg    = lcag_pkg::GRID_WIDTH_RST;
    height_reg   = lcag_pkg::GRID_HEIGHT_RST;
    for (int y = 0; y < SIDE; y++)
      life_grid[y] = '0;

    // synchronous reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, back to back
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_value);
      end else begin
        typed_res.alive = DIRECTED[i].alive;
        typed_res.valid = DIRECTED[i].valid;
        send_cmd(DIRECTED[i].op, DIRECTED[i].c, DIRECTED[i].r,
                 DIRECTED[i].chk == CHK_TYPED, typed_res);
      end
    end

    // random phases; cells left outside a shrunken grid show up again later
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = IDLE_PCT[p % 4];
      run_phase(PHASE_W[p], PHASE_H[p], CMDS_PER_PHASE);
    end

    // wait out the last results, then a little longer for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0)
      $display("life_cellular_automaton_grid: match");
    else
      $display("life_cellular_automaton_grid: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lcag_pkg.sv
design/lcag_ctrl.sv
design/lcag_datapath.sv
design/life_cellular_automaton_grid.sv
design/lcag_checker.sv
test/tb_life_cellular_automaton_grid.sv
